### src/lgr_pkg.sv
// Shared constants, codes and control/status bundles for the grid maze router.
`default_nettype none
package lgr_pkg;

  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_POINTS_DEF = 64;

  localparam int CFG_W   = 7;
  localparam int COORD_W = 6;
  localparam int MIN_DIM = 4;

  localparam logic [CFG_W-1:0] REG_RESET = 7'd64;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_ROUTE = 2'd2;

  localparam logic [1:0] ST_POINT = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_ACK   = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  localparam logic [1:0] ASEL_SRC = 2'd0;
  localparam logic [1:0] ASEL_DST = 2'd1;
  localparam logic [1:0] ASEL_NB  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       sweep_start;
    logic       obs_sweep;
    logic       dist_sweep;
    logic       obs_wr;
    logic       obs_rd;
    logic       dist_rd;
    logic [1:0] asel;
    logic       seed;
    logic       pop;
    logic       load_cur;
    logic       dir_clr;
    logic       dir_inc;
    logic       visit;
    logic       bt_init;
    logic       bt_move;
    logic       em_init;
    logic       ps_rd;
    logic       ps_use;
    logic       emit_ack;
    logic       emit_fail;
    logic       emit_fin;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic ends_oob;
    logic obs_hit;
    logic q_empty;
    logic at_target;
    logic nb_in;
    logic nb_free;
    logic dir_last;
    logic bt_stop;
    logic bt_hit;
    logic em_single;
    logic em_end;
  } sts_t;

endpackage
`default_nettype wire

### src/lgr_ctrl.sv
// Sequencing state machine of the grid maze router.
`default_nettype none
module lgr_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [1:0]   in_command,
  input  wire lgr_pkg::sts_t sts,
  output lgr_pkg::cmd_t     cmd,
  output logic              busy
);
  import lgr_pkg::*;

  localparam logic [4:0] S_RCLR  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WR    = 5'd2;
  localparam logic [4:0] S_CCLR  = 5'd3;
  localparam logic [4:0] S_RSRC  = 5'd4;
  localparam logic [4:0] S_RDST  = 5'd5;
  localparam logic [4:0] S_CDST  = 5'd6;
  localparam logic [4:0] S_DCLR  = 5'd7;
  localparam logic [4:0] S_SEED  = 5'd8;
  localparam logic [4:0] S_POP   = 5'd9;
  localparam logic [4:0] S_CUR   = 5'd10;
  localparam logic [4:0] S_NB    = 5'd11;
  localparam logic [4:0] S_NBCHK = 5'd12;
  localparam logic [4:0] S_BT    = 5'd13;
  localparam logic [4:0] S_BNB   = 5'd14;
  localparam logic [4:0] S_BCHK  = 5'd15;
  localparam logic [4:0] S_ERD   = 5'd16;
  localparam logic [4:0] S_EUSE  = 5'd17;
  localparam logic [4:0] S_EFIN  = 5'd18;
  localparam logic [4:0] S_FAIL  = 5'd19;

  logic [4:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RCLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.asel  = ASEL_SRC;
    state_nxt = state_r;
    unique case (state_r)
      S_RCLR: begin
        cmd.obs_sweep = 1'b1;
        if (sts.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (in_command)
            CMD_WRITE: state_nxt = S_WR;
            CMD_CLEAR: begin
              cmd.sweep_start = 1'b1;
              state_nxt = S_CCLR;
            end
            CMD_ROUTE: state_nxt = S_RSRC;
            default:   state_nxt = S_FAIL;
          endcase
        end
      end
      S_WR: begin
        cmd.obs_wr   = 1'b1;
        cmd.emit_ack = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CCLR: begin
        cmd.obs_sweep = 1'b1;
        if (sts.sweep_done) begin
          cmd.emit_ack = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RSRC: begin
        if (sts.ends_oob) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.obs_rd = 1'b1;
          state_nxt  = S_RDST;
        end
      end
      S_RDST: begin
        if (sts.obs_hit) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.obs_rd = 1'b1;
          cmd.asel   = ASEL_DST;
          state_nxt  = S_CDST;
        end
      end
      S_CDST: begin
        if (sts.obs_hit) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.sweep_start = 1'b1;
          state_nxt = S_DCLR;
        end
      end
      S_DCLR: begin
        cmd.dist_sweep = 1'b1;
        if (sts.sweep_done) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.q_empty) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        cmd.load_cur = 1'b1;
        cmd.dir_clr  = 1'b1;
        if (sts.at_target) begin
          cmd.bt_init = 1'b1;
          state_nxt   = S_BT;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        cmd.asel = ASEL_NB;
        if (sts.nb_in) begin
          cmd.obs_rd  = 1'b1;
          cmd.dist_rd = 1'b1;
          state_nxt   = S_NBCHK;
        end else if (sts.dir_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      S_NBCHK: begin
        cmd.asel  = ASEL_NB;
        cmd.visit = sts.nb_free;
        if (sts.dir_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.dir_inc = 1'b1;
          state_nxt   = S_NB;
        end
      end
      S_BT: begin
        if (sts.bt_stop) begin
          cmd.em_init = 1'b1;
          state_nxt   = S_ERD;
        end else begin
          cmd.dir_clr = 1'b1;
          state_nxt   = S_BNB;
        end
      end
      S_BNB: begin
        cmd.asel = ASEL_NB;
        if (sts.nb_in) begin
          cmd.dist_rd = 1'b1;
          state_nxt   = S_BCHK;
        end else if (sts.dir_last) begin
          cmd.em_init = 1'b1;
          state_nxt   = S_ERD;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      S_BCHK: begin
        if (sts.bt_hit) begin
          cmd.bt_move = 1'b1;
          state_nxt   = S_BT;
        end else if (sts.dir_last) begin
          cmd.em_init = 1'b1;
          state_nxt   = S_ERD;
        end else begin
          cmd.dir_inc = 1'b1;
          state_nxt   = S_BNB;
        end
      end
      S_ERD: begin
        cmd.ps_rd = 1'b1;
        state_nxt = S_EUSE;
      end
      S_EUSE: begin
        cmd.ps_use = 1'b1;
        if (sts.em_single) begin
          state_nxt = S_IDLE;
        end else if (sts.em_end) begin
          state_nxt = S_EFIN;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_EFIN: begin
        cmd.emit_fin = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_FAIL: begin
        cmd.emit_fail = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### src/lgr_dp.sv
// Datapath of the grid maze router: grid, wave, queue and path memories.
`default_nettype none
module lgr_dp #(
  parameter int MAX_COLS   = lgr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = lgr_pkg::MAX_ROWS_DEF,
  parameter int MAX_POINTS = lgr_pkg::MAX_POINTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_src_x,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_src_y,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_dst_x,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_dst_y,
  input  wire logic                         in_obstacle,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [lgr_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire lgr_pkg::cmd_t                cmd,
  output lgr_pkg::sts_t                     sts,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [lgr_pkg::COORD_W-1:0]       out_point_x,
  output logic [lgr_pkg::COORD_W-1:0]       out_point_y,
  output logic                              out_last
);
  import lgr_pkg::*;

  localparam int XW     = $clog2(MAX_COLS);
  localparam int YW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int QW     = AW + YW + XW;
  localparam int PTW    = YW + XW;
  localparam int PW     = $clog2(MAX_POINTS);
  localparam int LW     = $clog2(MAX_POINTS + 1);
  localparam int DW0    = (CW > RW) ? CW : RW;
  localparam int KW0    = (DW0 > COORD_W) ? DW0 : COORD_W;
  localparam int KW     = (KW0 > CFG_W) ? KW0 : CFG_W;
  localparam int SW     = KW + 1;
  localparam int PRW    = YW + CW + 1;

  // configuration
  logic [CFG_W-1:0] w_cfg_r, h_cfg_r, lim_cfg_r;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic [SW-1:0]    lim_raw;
  logic [LW-1:0]    lim;

  // latched transaction
  logic [COORD_W-1:0] sx_r, sy_r, tx_r, ty_r;
  logic               obst_r;
  logic [XW-1:0]      sxc, txc;
  logic [YW-1:0]      syc, tyc;

  // wave and path state
  logic [XW-1:0] cx_r, nbx;
  logic [YW-1:0] cy_r, nby;
  logic          nb_in;
  logic [AW-1:0] cd_r, cd_inc, cd_dec;
  logic [1:0]    dir_r;
  logic [AW:0]   head_r, tail_r;
  logic [AW-1:0] clr_r;
  logic [LW-1:0] len_r, j_r;
  logic [PW-1:0] rp_r;
  logic [PTW-1:0] pa_r, pb_r;

  // memories and registered read data
  logic            obs_mem [NCELLS];
  logic [AW:0]     dist_mem [NCELLS];
  logic [QW-1:0]   q_mem [NCELLS];
  logic [PTW-1:0]  ps_mem [MAX_POINTS];
  logic            obs_q;
  logic [AW:0]     dist_q;
  logic [QW-1:0]   q_q;
  logic [PTW-1:0]  ps_q;

  logic [XW-1:0]  ax, q_x;
  logic [YW-1:0]  ay, q_y;
  logic [AW-1:0]  q_d;
  logic [PRW-1:0] addr_full;
  logic [AW-1:0]  addr;
  logic           wr_in, corner;

  logic           obs_we, obs_wd;
  logic [AW-1:0]  obs_wa, dist_wa;
  logic           dist_we;
  logic [AW:0]    dist_wd;
  logic           q_we;
  logic [AW-1:0]  q_wa;
  logic [QW-1:0]  q_wd;
  logic           ps_we;
  logic [PW-1:0]  ps_wa;
  logic [PTW-1:0] ps_wd;

  logic                out_valid_r, out_last_r;
  logic [1:0]          out_status_r;
  logic [COORD_W-1:0]  out_point_x_r, out_point_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_cfg_r   <= REG_RESET;
      h_cfg_r   <= REG_RESET;
      lim_cfg_r <= REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  w_cfg_r   <= cfg_wdata;
        CFG_HEIGHT: h_cfg_r   <= cfg_wdata;
        CFG_LIMIT:  lim_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (KW'(w_cfg_r) < KW'(MIN_DIM)) begin
      w_eff = CW'(MIN_DIM);
    end else if (KW'(w_cfg_r) > KW'(MAX_COLS)) begin
      w_eff = CW'(MAX_COLS);
    end else begin
      w_eff = CW'(w_cfg_r);
    end
    if (KW'(h_cfg_r) < KW'(MIN_DIM)) begin
      h_eff = RW'(MIN_DIM);
    end else if (KW'(h_cfg_r) > KW'(MAX_ROWS)) begin
      h_eff = RW'(MAX_ROWS);
    end else begin
      h_eff = RW'(h_cfg_r);
    end
    if (lim_cfg_r == '0) begin
      lim_raw = SW'(w_eff) + SW'(h_eff);
    end else begin
      lim_raw = SW'(lim_cfg_r);
    end
    if (lim_raw > SW'(MAX_POINTS)) begin
      lim = LW'(MAX_POINTS);
    end else begin
      lim = LW'(lim_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sx_r   <= in_src_x;
      sy_r   <= in_src_y;
      tx_r   <= in_dst_x;
      ty_r   <= in_dst_y;
      obst_r <= in_obstacle;
    end
  end

  assign sxc = XW'(sx_r);
  assign syc = YW'(sy_r);
  assign txc = XW'(tx_r);
  assign tyc = YW'(ty_r);

  assign q_x = q_q[XW-1:0];
  assign q_y = q_q[PTW-1:XW];
  assign q_d = q_q[QW-1:PTW];

  assign cd_inc = cd_r + AW'(1);
  assign cd_dec = cd_r - AW'(1);

  assign wr_in = (KW'(sx_r) < KW'(w_eff)) && (KW'(sy_r) < KW'(h_eff));

  // neighbour of the current cell in the selected direction
  always_comb begin
    nbx   = cx_r;
    nby   = cy_r;
    nb_in = 1'b0;
    unique case (dir_r)
      DIR_UP: begin
        nby   = cy_r - YW'(1);
        nb_in = (cy_r != '0);
      end
      DIR_DOWN: begin
        nby   = cy_r + YW'(1);
        nb_in = (KW'(cy_r) + KW'(1)) < KW'(h_eff);
      end
      DIR_RIGHT: begin
        nbx   = cx_r + XW'(1);
        nb_in = (KW'(cx_r) + KW'(1)) < KW'(w_eff);
      end
      DIR_LEFT: begin
        nbx   = cx_r - XW'(1);
        nb_in = (cx_r != '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd.asel)
      ASEL_DST: begin
        ax = txc;
        ay = tyc;
      end
      ASEL_NB: begin
        ax = nbx;
        ay = nby;
      end
      default: begin
        ax = sxc;
        ay = syc;
      end
    endcase
  end

  assign addr_full = PRW'(ay) * PRW'(w_eff) + PRW'(ax);
  assign addr      = AW'(addr_full);

  assign corner = ({1'b0, pb_r[XW-1:0], 1'b0} !=
                   ((XW+2)'(pa_r[XW-1:0]) + (XW+2)'(ps_q[XW-1:0]))) ||
                  ({1'b0, pb_r[PTW-1:XW], 1'b0} !=
                   ((YW+2)'(pa_r[PTW-1:XW]) + (YW+2)'(ps_q[PTW-1:XW])));

  assign sts.nb_in      = nb_in;
  assign sts.sweep_done = (clr_r == AW'(NCELLS - 1));
  assign sts.ends_oob   = (KW'(sx_r) >= KW'(w_eff)) || (KW'(sy_r) >= KW'(h_eff)) ||
                          (KW'(tx_r) >= KW'(w_eff)) || (KW'(ty_r) >= KW'(h_eff));
  assign sts.obs_hit    = obs_q;
  assign sts.q_empty    = (head_r == tail_r);
  assign sts.at_target  = (q_x == txc) && (q_y == tyc);
  assign sts.nb_free    = !obs_q && !dist_q[AW];
  assign sts.dir_last   = (dir_r == DIR_LEFT);
  assign sts.bt_stop    = ((cx_r == sxc) && (cy_r == syc)) || (cd_r == '0);
  assign sts.bt_hit     = dist_q[AW] && (dist_q[AW-1:0] == cd_dec);
  assign sts.em_single  = (len_r == LW'(1));
  assign sts.em_end     = (j_r == len_r - LW'(1));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      dir_r  <= DIR_UP;
      len_r  <= '0;
      j_r    <= '0;
    end else begin
      if (cmd.sweep_start || ((cmd.obs_sweep || cmd.dist_sweep) && sts.sweep_done)) begin
        clr_r <= '0;
      end else if (cmd.obs_sweep || cmd.dist_sweep) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.seed) begin
        head_r <= '0;
        tail_r <= (AW+1)'(1);
      end else begin
        if (cmd.pop) head_r <= head_r + (AW+1)'(1);
        if (cmd.visit) tail_r <= tail_r + (AW+1)'(1);
      end
      if (cmd.dir_clr) begin
        dir_r <= DIR_UP;
      end else if (cmd.dir_inc) begin
        dir_r <= dir_r + 2'd1;
      end
      if (cmd.bt_init) begin
        len_r <= LW'(1);
      end else if (cmd.bt_move && (len_r < lim)) begin
        len_r <= len_r + LW'(1);
      end
      if (cmd.em_init) begin
        j_r <= '0;
      end else if (cmd.ps_use) begin
        j_r <= j_r + LW'(1);
      end
    end
  end

  // cursor and path window
  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cx_r <= q_x;
      cy_r <= q_y;
      cd_r <= q_d;
    end else if (cmd.bt_move) begin
      cx_r <= nbx;
      cy_r <= nby;
      cd_r <= cd_dec;
    end
    if (cmd.em_init) begin
      rp_r <= PW'(len_r - LW'(1));
    end else if (cmd.ps_use) begin
      rp_r <= rp_r - PW'(1);
    end
    if (cmd.ps_use) begin
      pa_r <= pb_r;
      pb_r <= ps_q;
    end
  end

  // obstacle grid
  assign obs_we = cmd.obs_sweep || (cmd.obs_wr && wr_in);
  assign obs_wa = cmd.obs_sweep ? clr_r : addr;
  assign obs_wd = cmd.obs_sweep ? 1'b0 : obst_r;

  always_ff @(posedge clk) begin
    if (obs_we) obs_mem[obs_wa] <= obs_wd;
    if (cmd.obs_rd) obs_q <= obs_mem[addr];
  end

  // wave distance with visited mark
  assign dist_we = cmd.dist_sweep || cmd.seed || cmd.visit;
  assign dist_wa = cmd.dist_sweep ? clr_r : addr;
  always_comb begin
    if (cmd.dist_sweep) begin
      dist_wd = '0;
    end else if (cmd.seed) begin
      dist_wd = {1'b1, AW'(0)};
    end else begin
      dist_wd = {1'b1, cd_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (cmd.dist_rd) dist_q <= dist_mem[addr];
  end

  // wave queue
  assign q_we = cmd.seed || cmd.visit;
  assign q_wa = cmd.seed ? AW'(0) : tail_r[AW-1:0];
  assign q_wd = cmd.seed ? {AW'(0), syc, sxc} : {cd_inc, nby, nbx};

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (cmd.pop) q_q <= q_mem[head_r[AW-1:0]];
  end

  // backtrace points, target first
  assign ps_we = cmd.bt_init || (cmd.bt_move && (len_r < lim));
  assign ps_wa = cmd.bt_init ? PW'(0) : len_r[PW-1:0];
  assign ps_wd = cmd.bt_init ? {q_y, q_x} : {nby, nbx};

  always_ff @(posedge clk) begin
    if (ps_we) ps_mem[ps_wa] <= ps_wd;
    if (cmd.ps_rd) ps_q <= ps_mem[rp_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_ack || cmd.emit_fail || cmd.emit_fin ||
                     (cmd.ps_use && ((j_r == '0) || ((j_r >= LW'(2)) && corner)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ack || cmd.emit_fail) begin
      out_status_r  <= cmd.emit_ack ? ST_ACK : ST_FAIL;
      out_point_x_r <= '0;
      out_point_y_r <= '0;
      out_last_r    <= 1'b1;
    end else if (cmd.emit_fin) begin
      out_status_r  <= ST_POINT;
      out_point_x_r <= COORD_W'(pb_r[XW-1:0]);
      out_point_y_r <= COORD_W'(pb_r[PTW-1:XW]);
      out_last_r    <= 1'b1;
    end else if (cmd.ps_use) begin
      out_status_r <= ST_POINT;
      if (j_r == '0) begin
        out_point_x_r <= COORD_W'(ps_q[XW-1:0]);
        out_point_y_r <= COORD_W'(ps_q[PTW-1:XW]);
        out_last_r    <= (len_r == LW'(1));
      end else begin
        out_point_x_r <= COORD_W'(pb_r[XW-1:0]);
        out_point_y_r <= COORD_W'(pb_r[PTW-1:XW]);
        out_last_r    <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_point_x = out_point_x_r;
  assign out_point_y = out_point_y_r;
  assign out_last    = out_last_r;

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r)
    else $error("result strobe directly after final transaction result");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("wave queue read ahead of write");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_POINTS))
    else $error("path length beyond store");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_POINT) |->
      out_last_r && (out_point_x_r == '0) && (out_point_y_r == '0))
    else $error("failure or acknowledge result malformed");

endmodule
`default_nettype wire

### src/lee_grid_maze_router.sv
// Lee maze router on an obstacle grid: top level.
// Commands are taken when start is high and busy low; each command yields one or more
// results, each shown for exactly one cycle on out_valid with no way to hold it off, the
// final one flagged by out_last. A grid clear sweeps the obstacle memory one cell a cycle.
// A route checks its endpoints, sweeps the distance memory, takes cells off the wave
// queue and visits their in-grid neighbours, backtraces from the target and emits the
// end and corner points of the stored path, each step paced by single-port accesses to
// the grid, distance, queue and path memories. After reset the block stays busy while
// it clears the obstacle memory.
`default_nettype none
module lee_grid_maze_router #(
  parameter int MAX_COLS   = lgr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = lgr_pkg::MAX_ROWS_DEF,
  parameter int MAX_POINTS = lgr_pkg::MAX_POINTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_command,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_src_x,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_src_y,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_dst_x,
  input  wire logic [lgr_pkg::COORD_W-1:0]  in_dst_y,
  input  wire logic                         in_obstacle,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [lgr_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [lgr_pkg::COORD_W-1:0]       out_point_x,
  output logic [lgr_pkg::COORD_W-1:0]       out_point_y,
  output logic                              out_last
);
  import lgr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  lgr_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_src_x    (in_src_x),
    .in_src_y    (in_src_y),
    .in_dst_x    (in_dst_x),
    .in_dst_y    (in_dst_y),
    .in_obstacle (in_obstacle),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

### tb/lee_grid_maze_router_tb.sv
// Testbench for the grid maze router: directed and random commands checked against a model.
`timescale 1ns / 100ps
module lee_grid_maze_router_tb;
  import lgr_pkg::*;

  typedef struct {
    logic [1:0] status;
    logic [5:0] px;
    logic [5:0] py;
    logic       last;
  } route_result_t;

  class route_scoreboard;
    bit            blocked[4096];
    int            wave_dist[4096];
    bit            seen[4096];
    int            wave[4096];
    int            trail_x[64];
    int            trail_y[64];
    logic [6:0]    width_reg  = REG_RESET;
    logic [6:0]    height_reg = REG_RESET;
    logic [6:0]    limit_reg  = REG_RESET;
    route_result_t awaited[$];
    int            errors = 0;

    function int clamp_dim(logic [6:0] v);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > 64) return 64;
      return int'(v);
    endfunction

    function void push(logic [1:0] st, int x, int y, bit lst);
      route_result_t r;
      r.status = st;
      r.px = x[5:0];
      r.py = y[5:0];
      r.last = lst;
      awaited.push_back(r);
    endfunction

    function int trace_route(int sx, int sy, int tx, int ty);
      int w, h, head, tail, cur, cx, cy, nx, ny, ni, cd, lim, len, tmp, d, i;
      int dx[4], dy[4];
      bit found, moved;
      dx = '{0, 0, 1, -1};
      dy = '{-1, 1, 0, 0};
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if (sx >= w || sy >= h || tx >= w || ty >= h) return 0;
      if (blocked[sy*w+sx] || blocked[ty*w+tx]) return 0;
      for (i = 0; i < 4096; i++) begin
        seen[i] = 0;
        wave_dist[i] = 0;
      end
      head = 0;
      tail = 0;
      found = 0;
      seen[sy*w+sx] = 1;
      wave[tail++] = sy*w+sx;
      while (head < tail) begin
        cur = wave[head++];
        cx = cur % w;
        cy = cur / w;
        if (cx == tx && cy == ty) begin
          found = 1;
          break;
        end
        for (d = 0; d < 4; d++) begin
          nx = cx + dx[d];
          ny = cy + dy[d];
          if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
          ni = ny*w + nx;
          if (blocked[ni] || seen[ni] || tail >= 4096) continue;
          seen[ni] = 1;
          wave_dist[ni] = wave_dist[cur] + 1;
          wave[tail++] = ni;
        end
      end
      if (!found) return 0;
      lim = int'(limit_reg);
      if (lim == 0) lim = w + h;
      if (lim > 64) lim = 64;
      cx = tx;
      cy = ty;
      trail_x[0] = cx;
      trail_y[0] = cy;
      len = 1;
      while (!(cx == sx && cy == sy)) begin
        cd = wave_dist[cy*w+cx];
        moved = 0;
        if (cd == 0) break;
        for (d = 0; d < 4; d++) begin
          nx = cx + dx[d];
          ny = cy + dy[d];
          if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
          ni = ny*w + nx;
          if (seen[ni] && wave_dist[ni] == cd - 1) begin
            cx = nx;
            cy = ny;
            moved = 1;
            if (len < lim) begin
              trail_x[len] = cx;
              trail_y[len] = cy;
              len++;
            end
            break;
          end
        end
        if (!moved) break;
      end
      for (i = 0; i < len/2; i++) begin
        tmp = trail_x[i]; trail_x[i] = trail_x[len-1-i]; trail_x[len-1-i] = tmp;
        tmp = trail_y[i]; trail_y[i] = trail_y[len-1-i]; trail_y[len-1-i] = tmp;
      end
      if (len == 1) begin
        push(ST_POINT, trail_x[0], trail_y[0], 1);
        return 1;
      end
      push(ST_POINT, trail_x[0], trail_y[0], 0);
      for (i = 1; i < len-1; i++) begin
        if (trail_x[i]-trail_x[i-1] == trail_x[i+1]-trail_x[i] &&
            trail_y[i]-trail_y[i-1] == trail_y[i+1]-trail_y[i]) continue;
        push(ST_POINT, trail_x[i], trail_y[i], 0);
      end
      push(ST_POINT, trail_x[len-1], trail_y[len-1], 1);
      return 1;
    endfunction

    function void note_command(logic [1:0] cmd, int sx, int sy, int tx, int ty, bit ob);
      int w, h, i;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      case (cmd)
        CMD_WRITE: begin
          if (sx < w && sy < h) blocked[sy*w+sx] = ob;
          push(ST_ACK, 0, 0, 1);
        end
        CMD_CLEAR: begin
          for (i = 0; i < 4096; i++) blocked[i] = 0;
          push(ST_ACK, 0, 0, 1);
        end
        CMD_ROUTE: begin
          if (trace_route(sx, sy, tx, ty) == 0) push(ST_FAIL, 0, 0, 1);
        end
        default: push(ST_FAIL, 0, 0, 1);
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [5:0] x, logic [5:0] y, logic lst);
      route_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status=%0d x=%0d y=%0d last=%0d",
                 $time, st, x, y, lst);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || x !== e.px || y !== e.py || lst !== e.last) begin
        $display("%0t: mismatch expected status=%0d x=%0d y=%0d last=%0d,",
                 $time, e.status, e.px, e.py, e.last,
                 " actual status=%0d x=%0d y=%0d last=%0d", st, x, y, lst);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       start = 0;
  logic       busy;
  logic [1:0] in_command = CMD_WRITE;
  logic [5:0] in_src_x = 0, in_src_y = 0, in_dst_x = 0, in_dst_y = 0;
  logic       in_obstacle = 0;
  logic       cfg_we = 0;
  logic [1:0] cfg_index = CFG_WIDTH;
  logic [6:0] cfg_wdata = 0;
  logic       out_valid;
  logic [1:0] out_status;
  logic [5:0] out_point_x, out_point_y;
  logic       out_last;

  route_scoreboard sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;

  lee_grid_maze_router DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_src_x(in_src_x), .in_src_y(in_src_y),
    .in_dst_x(in_dst_x), .in_dst_y(in_dst_y), .in_obstacle(in_obstacle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status), .out_point_x(out_point_x),
    .out_point_y(out_point_y), .out_last(out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_point_x, out_point_y, out_last);
    if ((rst_n && start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 250000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, int sx, int sy, int tx, int ty, bit ob);
    start <= 1;
    in_command <= cmd;
    in_src_x <= sx[5:0];
    in_src_y <= sy[5:0];
    in_dst_x <= tx[5:0];
    in_dst_y <= ty[5:0];
    in_obstacle <= ob;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd, sx, sy, tx, ty, ob);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [6:0] w, logic [6:0] h, logic [6:0] lim);
    drain();
    cfg_we <= 1; cfg_index <= CFG_WIDTH; cfg_wdata <= w;
    @(posedge clk);
    sb.width_reg = w;
    cfg_index <= CFG_HEIGHT; cfg_wdata <= h;
    @(posedge clk);
    sb.height_reg = h;
    cfg_index <= CFG_LIMIT; cfg_wdata <= lim;
    @(posedge clk);
    sb.limit_reg = lim;
    cfg_we <= 0;
  endtask

  task automatic random_items(int n);
    int w, h, r;
    w = sb.clamp_dim(sb.width_reg);
    h = sb.clamp_dim(sb.height_reg);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45)
        send(CMD_WRITE, $urandom_range(w-1), $urandom_range(h-1), $urandom_range(63),
             $urandom_range(63), $urandom_range(99) < 35);
      else if (r < 50)
        send(CMD_WRITE, $urandom_range(63), $urandom_range(63), $urandom_range(63),
             $urandom_range(63), $urandom_range(1));
      else if (r < 54)
        send(CMD_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(63),
             $urandom_range(63), $urandom_range(1));
      else if (r < 58)
        send(2'd3, $urandom_range(63), $urandom_range(63), $urandom_range(63),
             $urandom_range(63), $urandom_range(1));
      else if (r < 66)
        send(CMD_ROUTE, $urandom_range(63), $urandom_range(63), $urandom_range(63),
             $urandom_range(63), $urandom_range(1));
      else
        send(CMD_ROUTE, $urandom_range(w-1), $urandom_range(h-1), $urandom_range(w-1),
             $urandom_range(h-1), $urandom_range(1));
    end
  endtask

  initial begin
    int y;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(CMD_ROUTE, 0, 0, 0, 0, 0);
    send(CMD_ROUTE, 0, 0, 63, 63, 0);
    send(CMD_WRITE, 63, 63, 0, 0, 1);
    send(CMD_ROUTE, 0, 0, 63, 63, 0);
    send(2'd3, 63, 63, 63, 63, 1);
    send(CMD_CLEAR, 0, 0, 0, 0, 0);
    send(CMD_ROUTE, 5, 5, 5, 9, 0);

    configure(7'd8, 7'd8, 7'd64);
    idle_pct = 52;
    send(CMD_WRITE, 63, 63, 0, 0, 1);
    for (y = 0; y < 7; y++) send(CMD_WRITE, 3, y, 0, 0, 1);
    send(CMD_ROUTE, 0, 0, 7, 0, 0);
    send(CMD_WRITE, 3, 7, 0, 0, 1);
    send(CMD_ROUTE, 0, 0, 7, 0, 0);
    send(CMD_CLEAR, 0, 0, 0, 0, 0);
    random_items(25);

    drain();
    idle_pct = 0;
    random_items(15);

    configure(7'd0, 7'd127, 7'd0);
    send(CMD_ROUTE, 0, 0, 3, 63, 0);
    send(CMD_ROUTE, 4, 0, 0, 0, 0);
    random_items(12);

    configure(7'd127, 7'd4, 7'd1);
    idle_pct = 36;
    send(CMD_ROUTE, 0, 0, 63, 3, 0);
    random_items(10);

    configure(7'd6, 7'd10, 7'd3);
    idle_pct = 52;
    random_items(15);
    idle_pct = 0;
    random_items(10);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
